[design/gwrf_pkg.sv]
// Package for the gap window region filter.
// Holds widths, register indexes, the queue entry type and the flag counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gwrf_pkg;

  localparam int SPECIES    = 8;
  localparam int MAX_WINDOW = 64;
  localparam int MAX_BLOCK  = 65536;

  localparam int FLAG_W   = 8;   // column_flags
  localparam int CNT_W    = 4;   // flag count of one column
  localparam int SUM_W    = 10;  // running window sum
  localparam int CIDX_W   = 17;  // column index / region end
  localparam int POS_W    = 16;  // region start
  localparam int PHASE_W  = 6;
  localparam int WSZ_W    = 7;   // window_size and step registers
  localparam int MAXF_W   = 10;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = 6;
  localparam int WIN_CAP    = (MAX_WINDOW < RING_DEPTH) ? MAX_WINDOW : RING_DEPTH;
  localparam int STEP_CAP   = 64;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 10;

  localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_STEP        = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_FLAGGED = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam int OUT_DW = 40;

  // One classified column: a bad window ending at e, the block end, or both.
  typedef struct packed {
    logic              bad;
    logic              last;
    logic [POS_W-1:0]  ws;
    logic [CIDX_W-1:0] e;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CNT_W-1:0] count_flags(input logic [FLAG_W-1:0] f);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < FLAG_W; i++) begin
      if (i < SPECIES) begin
        n = n + CNT_W'(f[i]);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[design/gwrf_front.sv]
// Front part: configuration registers, column ring, running window sum and
// window evaluation. Pushes bad-window and block-end words into the queue.
// Depends on gwrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrf_front
  import gwrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [FLAG_W-1:0] in_tdata,
  input  wire logic              in_tlast,
  input  wire q_stat_t           q_stat,
  output logic                   push,
  output ev_t                    push_ev
);

  logic [WSZ_W-1:0]   window_size_r;
  logic [WSZ_W-1:0]   step_r;
  logic [MAXF_W-1:0]  max_flagged_r;

  logic [CIDX_W-1:0]  col_r, col_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;

  logic [CNT_W-1:0]   ring [RING_DEPTH];

  // stage A
  logic               a_valid_r;
  logic [CNT_W-1:0]   a_cnt_r;
  logic [CNT_W-1:0]   a_rd_r;
  logic               a_sub_r;
  logic               a_eval_r;
  logic [POS_W-1:0]   a_ws_r;
  logic [CIDX_W-1:0]  a_e_r;
  logic               a_last_r;

  logic [WSZ_W-1:0]   w_eff;
  logic [WSZ_W-1:0]   st_eff;
  logic [CIDX_W-1:0]  e;
  logic               eval;
  logic               last;
  logic               sub;
  logic               accept;
  logic               consume;
  logic [RING_AW-1:0] rd_addr;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   sum_sub;
  logic               bad;

  always_comb begin
    if (window_size_r == '0) begin
      w_eff = WSZ_W'(1);
    end else if (window_size_r > WSZ_W'(WIN_CAP)) begin
      w_eff = WSZ_W'(WIN_CAP);
    end else begin
      w_eff = window_size_r;
    end
    if (step_r == '0) begin
      st_eff = WSZ_W'(1);
    end else if (step_r > WSZ_W'(STEP_CAP)) begin
      st_eff = WSZ_W'(STEP_CAP);
    end else begin
      st_eff = step_r;
    end
  end

  assign cnt     = count_flags(in_tdata);
  assign e       = col_r + CIDX_W'(1);
  assign sub     = col_r >= CIDX_W'(w_eff);
  assign rd_addr = col_r[RING_AW-1:0] - RING_AW'(w_eff);
  assign last    = in_tlast || (e >= CIDX_W'(MAX_BLOCK));

  always_comb begin
    eval      = 1'b0;
    phase_nxt = phase_r;
    if (e == CIDX_W'(w_eff)) begin
      eval      = 1'b1;
      phase_nxt = '0;
    end else if (e > CIDX_W'(w_eff)) begin
      if (({1'b0, phase_r} + WSZ_W'(1)) >= st_eff) begin
        eval      = 1'b1;
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
    end
    if (last) begin
      phase_nxt = '0;
    end
  end

  assign col_nxt = last ? '0 : e;

  // stage A advances whenever the queue has room
  assign consume   = a_valid_r && !q_stat.full;
  assign in_tready = !a_valid_r || !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  assign sum_sub = a_sub_r ? (sum_r - SUM_W'(a_rd_r)) : sum_r;
  assign sum_nxt = sum_sub + SUM_W'(a_cnt_r);
  assign bad     = a_eval_r && (sum_nxt > max_flagged_r);

  assign push         = consume && (bad || a_last_r);
  assign push_ev.bad  = bad;
  assign push_ev.last = a_last_r;
  assign push_ev.ws   = a_ws_r;
  assign push_ev.e    = a_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WSZ_W'(10);
      step_r        <= WSZ_W'(1);
      max_flagged_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_SIZE: window_size_r <= cfg_wdata[WSZ_W-1:0];
        REG_STEP:        step_r        <= cfg_wdata[WSZ_W-1:0];
        REG_MAX_FLAGGED: max_flagged_r <= cfg_wdata[MAXF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      phase_r   <= '0;
      sum_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r   <= col_nxt;
        phase_r <= phase_nxt;
      end
      if (consume) begin
        sum_r <= a_last_r ? '0 : sum_nxt;
      end
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (consume) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  // the leaving column is read before the new count lands (same slot when w is full depth)
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[col_r[RING_AW-1:0]] <= cnt;
      a_rd_r                   <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cnt_r  <= cnt;
      a_sub_r  <= sub;
      a_eval_r <= eval;
      a_ws_r   <= POS_W'(e - CIDX_W'(w_eff));
      a_e_r    <= e;
      a_last_r <= last;
    end
  end

endmodule

`default_nettype wire

[design/gwrf_queue.sv]
// Short queue of classified words between the front and back parts.
// Depends on gwrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrf_queue
  import gwrf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire ev_t  push_ev,
  input  wire logic pop,
  output ev_t       head,
  output q_stat_t   q_stat
);

  ev_t            mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign head         = mem[rd_ptr_r];
  assign q_stat.full  = count_r == (QAW+1)'(QDEPTH);
  assign q_stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_ev;
    end
  end

endmodule

`default_nettype wire

[design/gwrf_back.sv]
// Back part: keeps the open region, merges bad windows into it and emits
// finished regions and the block-end result through an output register.
// Depends on gwrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrf_back
  import gwrf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ev_t         head,
  input  wire q_stat_t     q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [POS_W-1:0] out_start,
  output logic [CIDX_W-1:0] out_end,
  output logic             out_has,
  output logic             out_last
);

  logic              open_r;
  logic [POS_W-1:0]  start_r;
  logic [CIDX_W-1:0] end_r;
  logic              done_r;     // bad part of the head word already handled
  logic              out_valid_r;
  logic [POS_W-1:0]  out_start_r;
  logic [CIDX_W-1:0] out_end_r;
  logic              out_has_r;
  logic              out_last_r;

  logic              can_out;
  logic              apply;
  logic              disjoint;
  logic              need_emit;
  logic              fire;
  logic              n_open;
  logic [POS_W-1:0]  n_start;
  logic [CIDX_W-1:0] n_end;
  logic [POS_W-1:0]  o_start;
  logic [CIDX_W-1:0] o_end;
  logic              o_has;

  assign can_out   = !out_valid_r || out_tready;
  assign apply     = head.bad && !done_r;
  assign disjoint  = apply && open_r && (CIDX_W'(head.ws) > end_r);
  assign need_emit = disjoint || head.last;
  assign fire      = !q_stat.empty && (!need_emit || can_out);
  // a disjoint window on the last column takes two results: hold the word
  assign pop       = fire && !(disjoint && head.last);

  always_comb begin
    n_open  = open_r;
    n_start = start_r;
    n_end   = end_r;
    if (apply) begin
      n_open = 1'b1;
      n_end  = head.e;
      if (!open_r || disjoint) begin
        n_start = head.ws;
      end
    end
  end

  always_comb begin
    if (disjoint) begin
      o_start = start_r;
      o_end   = end_r;
      o_has   = 1'b1;
    end else if (n_open) begin
      o_start = n_start;
      o_end   = n_end;
      o_has   = 1'b1;
    end else begin
      o_start = '0;
      o_end   = '0;
      o_has   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        if (disjoint && head.last) begin
          start_r <= head.ws;
          end_r   <= head.e;
          done_r  <= 1'b1;
        end else if (head.last) begin
          open_r  <= 1'b0;
          start_r <= '0;
          end_r   <= '0;
          done_r  <= 1'b0;
        end else begin
          open_r  <= n_open;
          start_r <= n_start;
          end_r   <= n_end;
          done_r  <= 1'b0;
        end
      end
      if (fire && need_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && need_emit) begin
      out_start_r <= o_start;
      out_end_r   <= o_end;
      out_has_r   <= o_has;
      out_last_r  <= !disjoint;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_start  = out_start_r;
  assign out_end    = out_end_r;
  assign out_has    = out_has_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[design/gap_window_region_filter.sv]
// Gap window region filter: one column word per cycle while the queue has room,
// results one per cycle while out_tready is high. A column passes the stage A
// register, the queue and the output register. A column that closes a region and
// ends the block yields two results; the back part keeps its word at the head until
// both are out. The four-entry queue absorbs that and output stalls.
// Reset (rst_n low, synchronous): registers to 10 / 1 / 0, block state cleared.
`timescale 1ns / 1ps
`default_nettype none

module gap_window_region_filter
  import gwrf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [FLAG_W-1:0] in_tdata,   // [7:0] column_flags
  input  wire logic              in_tlast,   // last_column
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // [15:0] region_start, [32:16] region_end
  output logic                   out_tuser,  // [0] has_region
  output logic                   out_tlast   // block_end
);

  q_stat_t           q_stat;
  logic              push;
  ev_t               push_ev;
  logic              pop;
  ev_t               head;
  logic [POS_W-1:0]  out_start;
  logic [CIDX_W-1:0] out_end;

  gwrf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_ev   (push_ev)
  );

  gwrf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  gwrf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_start  (out_start),
    .out_end    (out_end),
    .out_has    (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {(OUT_DW-POS_W-CIDX_W)'(0), out_end, out_start};

endmodule

`default_nettype wire

[design/gwrf_chk.sv]
// Port checker for the gap window region filter, bound to the top level.
// Depends on gwrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gwrf_chk
  import gwrf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tuser,
  input wire logic              out_tlast
);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

  // a word without a region is only the block-end word, and carries zeros
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("empty result word is not a zero block-end word");

  // a region is never empty
  a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[32:16] > {1'b0, out_tdata[15:0]})
    else $error("region end not past region start");

  // a region closed mid-block is followed by one that starts past its end
  a_region_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser && !out_tlast ##1 out_tvalid && out_tuser
      |-> {1'b0, out_tdata[15:0]} > $past(out_tdata[32:16]))
    else $error("successive regions overlap");

endmodule

bind gap_window_region_filter gwrf_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
